[design/spr_rle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_rle_pkg
// Shared constants and types of the transparent-pixel run-length encoder.
// ----------------------------------------------------------------------------
package spr_rle_pkg;

    localparam int OBUF_DEPTH = 127;
    localparam int PIX_W      = 8;
    localparam int TCOUNT_W   = 11;
    localparam int LANES      = 4;
    localparam int OUT_W      = 40;

    localparam logic [6:0]          RUN_MAX     = 7'd127;
    localparam logic [6:0]          RUN_NEAR    = 7'd126;
    localparam logic [TCOUNT_W-1:0] TCOUNT_MAX  = 11'd2047;
    localparam logic [7:0]          SKIP_FULL   = 8'hFF;
    localparam logic [7:0]          SKIP_FLAG   = 8'h80;
    localparam logic [7:0]          ROW_MARK    = 8'h80;
    localparam logic [7:0]          TERM_BYTE   = 8'hEE;
    localparam logic [1:0]          TERM_LAST   = 2'd2;
    localparam logic [2:0]          PACK_FULL   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SKIP,
        ST_APPEND,
        ST_OPQ_CNT,
        ST_OPQ_DATA,
        ST_TINC,
        ST_ROW_MARK,
        ST_TERM,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        BSEL_SKIP,
        BSEL_COUNT,
        BSEL_PIXEL,
        BSEL_ROW,
        BSEL_TERM
    } byte_sel_t;

    typedef struct packed {
        logic      capture;
        logic      append;
        logic      tinc;
        logic      emit;
        byte_sel_t sel;
        logic      push_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic item_zero;
        logic item_row;
        logic item_frame;
        logic ocount_zero;
        logic ocount_near_full;
        logic tcount_zero;
        logic skip_last;
        logic idx_last;
        logic term_last;
        logic emit_ready;
        logic pack_empty;
        logic out_free;
    } dp_status_t;

endpackage

[design/spr_rle_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_rle_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spr_rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/spr_rle_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_rle_dp
// Datapath: item capture, run counters, opaque pixel buffer, byte packer
// and output register.
// ----------------------------------------------------------------------------
module spr_rle_dp
    import spr_rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  logic [PIX_W-1:0] in_pixel,
    input  logic             in_row_end,
    input  logic             in_frame_end,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data,
    output logic             out_last,
    output logic             out_term
);

    logic [PIX_W-1:0]    pixel_reg, pixel_next;
    logic                row_reg, row_next;
    logic                frame_reg, frame_next;
    logic [6:0]          ocount_reg, ocount_next;
    logic [TCOUNT_W-1:0] tcount_reg, tcount_next;
    logic [6:0]          idx_reg, idx_next;
    logic [1:0]          term_cnt_reg, term_cnt_next;

    logic [7:0]          lane_reg [LANES];
    logic [7:0]          lane_next [LANES];
    logic [2:0]          pack_cnt_reg, pack_cnt_next;
    logic                pack_term_reg, pack_term_next;

    logic [7:0]          out_byte_reg [LANES];
    logic [7:0]          out_byte_next [LANES];
    logic [2:0]          out_cnt_reg, out_cnt_next;
    logic                out_last_reg, out_last_next;
    logic                out_term_reg, out_term_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]          rd_data;
    logic [7:0]          emit_byte;
    logic                emit_is_term;
    logic                emit_ready;
    logic                fire;
    logic                out_free;
    logic                tcount_big;
    logic [6:0]          ocount_m1;

    assign out_free   = !out_valid_reg || out_ready;
    assign emit_ready = (pack_cnt_reg != PACK_FULL) || out_free;
    assign fire       = cmd.emit && emit_ready;
    assign tcount_big = tcount_reg >= {4'b0, RUN_MAX};
    assign ocount_m1  = ocount_reg - 7'd1;

    spr_rle_ram #(
        .WIDTH (PIX_W),
        .DEPTH (OBUF_DEPTH)
    ) u_obuf (
        .clk     (clk),
        .wr_en   (cmd.append),
        .wr_addr (ocount_reg),
        .wr_data (pixel_reg),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    always_comb
    begin
        emit_is_term = 1'b0;
        case (cmd.sel)
            BSEL_SKIP:  emit_byte = tcount_big ? SKIP_FULL : (SKIP_FLAG | {1'b0, tcount_reg[6:0]});
            BSEL_COUNT: emit_byte = {1'b0, ocount_reg};
            BSEL_PIXEL: emit_byte = rd_data;
            BSEL_ROW:   emit_byte = ROW_MARK;
            BSEL_TERM:
            begin
                emit_byte    = TERM_BYTE;
                emit_is_term = 1'b1;
            end
            default:    emit_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        pixel_next    = pixel_reg;
        row_next      = row_reg;
        frame_next    = frame_reg;
        ocount_next   = ocount_reg;
        tcount_next   = tcount_reg;
        idx_next      = idx_reg;
        term_cnt_next = term_cnt_reg;

        if (cmd.capture)
        begin
            pixel_next = in_pixel;
            row_next   = in_row_end || in_frame_end;
            frame_next = in_frame_end;
        end
        if (cmd.append)
        begin
            ocount_next = ocount_reg + 7'd1;
        end
        if (cmd.tinc && (tcount_reg != TCOUNT_MAX))
        begin
            tcount_next = tcount_reg + 11'd1;
        end
        if (fire)
        begin
            case (cmd.sel)
                BSEL_SKIP:
                begin
                    tcount_next = tcount_big ? (tcount_reg - {4'b0, RUN_MAX}) : '0;
                end
                BSEL_COUNT: idx_next = '0;
                BSEL_PIXEL:
                begin
                    idx_next = idx_reg + 7'd1;
                    if (idx_reg == ocount_m1)
                    begin
                        ocount_next = '0;
                    end
                end
                BSEL_ROW:   tcount_next = '0;
                BSEL_TERM:  term_cnt_next = (term_cnt_reg == TERM_LAST) ? 2'd0
                                                                        : term_cnt_reg + 2'd1;
                default:    idx_next = idx_reg;
            endcase
        end
    end

    // byte packer; a full word moves out only when the next byte arrives,
    // so the item's final word can carry the last flag
    always_comb
    begin
        lane_next      = lane_reg;
        pack_cnt_next  = pack_cnt_reg;
        pack_term_next = pack_term_reg;
        out_byte_next  = out_byte_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_term_next  = out_term_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (fire)
        begin
            if (pack_cnt_reg == PACK_FULL)
            begin
                out_byte_next  = lane_reg;
                out_cnt_next   = PACK_FULL;
                out_last_next  = 1'b0;
                out_term_next  = pack_term_reg;
                out_valid_next = 1'b1;
                lane_next[0]   = emit_byte;
                pack_cnt_next  = 3'd1;
                pack_term_next = emit_is_term;
            end
            else
            begin
                lane_next[pack_cnt_reg[1:0]] = emit_byte;
                pack_cnt_next  = pack_cnt_reg + 3'd1;
                pack_term_next = pack_term_reg || emit_is_term;
            end
        end
        else if (cmd.push_final && out_free && (pack_cnt_reg != 3'd0))
        begin
            for (int j = 0; j < LANES; j++)
            begin
                out_byte_next[j] = (3'(j) < pack_cnt_reg) ? lane_reg[j] : 8'h00;
            end
            out_cnt_next   = pack_cnt_reg;
            out_last_next  = 1'b1;
            out_term_next  = pack_term_reg;
            out_valid_next = 1'b1;
            pack_cnt_next  = '0;
            pack_term_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 1'b0;
            frame_reg     <= 1'b0;
            ocount_reg    <= '0;
            tcount_reg    <= '0;
            idx_reg       <= '0;
            term_cnt_reg  <= '0;
            pack_cnt_reg  <= '0;
            pack_term_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_term_reg  <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            frame_reg     <= frame_next;
            ocount_reg    <= ocount_next;
            tcount_reg    <= tcount_next;
            idx_reg       <= idx_next;
            term_cnt_reg  <= term_cnt_next;
            pack_cnt_reg  <= pack_cnt_next;
            pack_term_reg <= pack_term_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_term_reg  <= out_term_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg    <= pixel_next;
        lane_reg     <= lane_next;
        out_byte_reg <= out_byte_next;
        out_cnt_reg  <= out_cnt_next;
    end

    always_comb
    begin
        status.in_zero          = (in_pixel == '0);
        status.item_zero        = (pixel_reg == '0);
        status.item_row         = row_reg;
        status.item_frame       = frame_reg;
        status.ocount_zero      = (ocount_reg == '0);
        status.ocount_near_full = (ocount_reg == RUN_NEAR);
        status.tcount_zero      = (tcount_reg == '0);
        status.skip_last        = (tcount_reg <= {4'b0, RUN_MAX});
        status.idx_last         = (idx_reg == ocount_m1);
        status.term_last        = (term_cnt_reg == TERM_LAST);
        status.emit_ready       = emit_ready;
        status.pack_empty       = (pack_cnt_reg == '0);
        status.out_free         = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {5'b0, out_cnt_reg, out_byte_reg[3], out_byte_reg[2],
                        out_byte_reg[1], out_byte_reg[0]};
    assign out_last  = out_last_reg;
    assign out_term  = out_term_reg;

endmodule

[design/spr_rle_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_rle_ctrl
// Controller: sequences skip, opaque flush, row mark and terminator bytes
// for one pixel request at a time.
// ----------------------------------------------------------------------------
module spr_rle_ctrl
    import spr_rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = BSEL_SKIP;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    if (status.in_zero)
                    begin
                        state_next = status.ocount_zero ? ST_TINC : ST_OPQ_CNT;
                    end
                    else
                    begin
                        state_next = status.tcount_zero ? ST_APPEND : ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = BSEL_SKIP;
                if (status.emit_ready && status.skip_last)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                if (status.ocount_near_full || status.item_row)
                begin
                    state_next = ST_OPQ_CNT;
                end
                else
                begin
                    state_next = status.pack_empty ? ST_IDLE : ST_FINISH;
                end
            end
            ST_OPQ_CNT:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = BSEL_COUNT;
                if (status.emit_ready)
                begin
                    state_next = ST_OPQ_DATA;
                end
            end
            ST_OPQ_DATA:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = BSEL_PIXEL;
                if (status.emit_ready && status.idx_last)
                begin
                    if (status.item_zero)
                    begin
                        state_next = ST_TINC;
                    end
                    else
                    begin
                        state_next = status.item_row ? ST_ROW_MARK : ST_FINISH;
                    end
                end
            end
            ST_TINC:
            begin
                cmd.tinc = 1'b1;
                if (status.item_row)
                begin
                    state_next = ST_ROW_MARK;
                end
                else
                begin
                    state_next = status.pack_empty ? ST_IDLE : ST_FINISH;
                end
            end
            ST_ROW_MARK:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = BSEL_ROW;
                if (status.emit_ready)
                begin
                    state_next = status.item_frame ? ST_TERM : ST_FINISH;
                end
            end
            ST_TERM:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = BSEL_TERM;
                if (status.emit_ready && status.term_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.push_final = 1'b1;
                if (status.out_free || status.pack_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/sprite_transparent_rle_encoder_unit.sv]
`timescale 1ns / 1ps
// A pixel that causes no byte only updates the pixel buffer or the transparent run counter;
// otherwise its encoded bytes are packed until the last word sits in the output register.
// Requests are taken one at a time, a new one only after the previous one's last word
// is loaded, or after the buffer or run counter update for a pixel with no byte.
// Bytes are made at one per cycle (single buffer read port); output stalls add cycles.
// Reset clears the run counters, packer and output valid; the pixel buffer is not cleared.
// ----------------------------------------------------------------------------
// sprite_transparent_rle_encoder_unit
// Transparent-pixel run-length encoder for 8-bit palette sprites, four
// encoded bytes per output word.
// ----------------------------------------------------------------------------
module sprite_transparent_rle_encoder_unit
    import spr_rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
    input  logic             s_axis_tuser,   // [0] row_end
    input  logic             s_axis_tlast,   // frame_end
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [7:0] byte_a, [15:8] byte_b, [23:16] byte_c,
                                             // [31:24] byte_d, [34:32] byte_count, rest 0
    output logic             m_axis_tuser,   // [0] frame_done
    output logic             m_axis_tlast    // last word of the request
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    spr_rle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spr_rle_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_pixel     (s_axis_tdata),
        .in_row_end   (s_axis_tuser),
        .in_frame_end (s_axis_tlast),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .out_term     (m_axis_tuser)
    );

endmodule

[design/spr_rle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_rle_checker
// Port-level checks of the encoder output words, bound to the top level.
// ----------------------------------------------------------------------------
module spr_rle_checker
    import spr_rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tready,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             m_axis_tuser,
    input  logic             m_axis_tlast
);

    logic [2:0] word_cnt;

    assign word_cnt = m_axis_tdata[34:32];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (word_cnt != 3'd0) && (word_cnt <= PACK_FULL))
        else $error("byte count out of range");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> word_cnt == PACK_FULL)
        else $error("partial word before end of request");

    // terminator bytes close the request, so a non-final word that holds
    // one ends with one
    a_term_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> m_axis_tdata[31:24] == TERM_BYTE)
        else $error("terminator word not ending in terminator byte");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("new request taken before previous one finished");

endmodule

bind sprite_transparent_rle_encoder_unit spr_rle_checker u_checker (.*);
